// ===== hdl/tolerant_template_match_defines.svh =====
// Assertion macros used by the matcher back end (tmm_back).
`ifndef TOLERANT_TEMPLATE_MATCH_DEFINES_SVH
`define TOLERANT_TEMPLATE_MATCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TMM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmm assertion failed");
`define TMM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tmm forbidden condition seen");
`else
`define TMM_ASSERT(lbl, prop)
`define TMM_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/tmm_pkg.sv =====
`timescale 1ns / 1ps
package tmm_pkg;

  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 11;
  localparam int HAY_MAX_H = 1024;
  localparam int JOB_AW  = 21;
  localparam int JOB_LW  = 8;

  localparam logic [1:0] OP_NEEDLE  = 2'd0;
  localparam logic [1:0] OP_HAY     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_NEEDLE_W = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_NEEDLE_H = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_HAY_W    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_HAY_H    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_TOL      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_OPAC     = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [9:0] match_left;
    logic [9:0] match_top;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  nw;
    logic [5:0]  nh;
    logic [10:0] hw;
    logic [10:0] hh;
    logic [8:0]  tol;
    logic [7:0]  lim;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_NEEDLE,
    JOB_HAY,
    JOB_CHECK
  } job_kind_t;

  // One request as handed from front to back.
  typedef struct packed {
    job_kind_t          kind;
    logic [31:0]        pixel;
    logic [JOB_AW-1:0]  waddr;
    logic [JOB_AW-1:0]  rbase;
    logic [JOB_LW-1:0]  top_line;
    logic [10:0]        left;
    logic [10:0]        top;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_DONE
  } back_state_t;

  function automatic logic chan_close(logic [7:0] a, logic [7:0] b, logic [8:0] tol);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return ({1'b0, d} <= tol);
  endfunction

  function automatic logic pixels_agree(logic [31:0] h, logic [31:0] n,
                                        logic [8:0] tol, logic [7:0] lim);
    logic skip;
    skip = (lim != 8'd0) && ((h[31:24] >= lim) || (n[31:24] >= lim));
    return skip || (chan_close(h[7:0], n[7:0], tol) &&
                    chan_close(h[15:8], n[15:8], tol) &&
                    chan_close(h[23:16], n[23:16], tol));
  endfunction

endpackage

// ===== hdl/tmm_fifo.sv =====
`timescale 1ns / 1ps
module tmm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tmm_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tmm_pkg::job_t head
);
  import tmm_pkg::*;

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hdl/tmm_front.sv =====
`timescale 1ns / 1ps
module tmm_front #(
  parameter int NEEDLE_MAX_W = 32,
  parameter int NEEDLE_MAX_H = 32,
  parameter int HAY_MAX_W    = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmm_pkg::in_item_t in_data,
  input  tmm_pkg::cfg_t     cfg,
  input  logic              cfg_restart,
  input  logic              q_full,
  output logic              q_push,
  output tmm_pkg::job_t     q_data
);
  import tmm_pkg::*;

  localparam int ND  = NEEDLE_MAX_W * NEEDLE_MAX_H;
  localparam int NAW = (ND > 1) ? $clog2(ND) : 1;
  localparam int LNW = (NEEDLE_MAX_H > 1) ? $clog2(NEEDLE_MAX_H) : 1;
  localparam int LAW = $clog2(NEEDLE_MAX_H * HAY_MAX_W);

  logic [NAW-1:0] nidx_r,  nidx_nxt;
  logic [10:0]    hcol_r,  hcol_nxt;
  logic [10:0]    hrow_r,  hrow_nxt;
  logic [LNW-1:0] hline_r, hline_nxt;
  logic [LAW-1:0] hbase_r, hbase_nxt;

  logic           acc;
  logic           check;
  logic [5:0]     nh1;
  logic [LNW-1:0] tline;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign nh1      = cfg.nh - 6'd1;
  assign check    = ({1'b0, hcol_r} + 12'd1 >= {6'd0, cfg.nw}) &&
                    ({1'b0, hrow_r} + 12'd1 >= {6'd0, cfg.nh});

  // line of the window's top row, modulo the line count
  always_comb begin
    if (int'(hline_r) >= int'(nh1)) begin
      tline = LNW'(int'(hline_r) - int'(nh1));
    end else begin
      tline = LNW'(int'(hline_r) + NEEDLE_MAX_H - int'(nh1));
    end
  end

  always_comb begin
    nidx_nxt  = nidx_r;
    hcol_nxt  = hcol_r;
    hrow_nxt  = hrow_r;
    hline_nxt = hline_r;
    hbase_nxt = hbase_r;
    q_push    = 1'b0;
    q_data.kind     = JOB_HAY;
    q_data.pixel    = in_data.pixel;
    q_data.waddr    = JOB_AW'(LAW'(hbase_r + LAW'(hcol_r)));
    q_data.rbase    = JOB_AW'(LAW'(int'(tline) * HAY_MAX_W));
    q_data.top_line = JOB_LW'(tline);
    q_data.left     = hcol_r + 11'd1 - {5'd0, cfg.nw};
    q_data.top      = hrow_r + 11'd1 - {5'd0, cfg.nh};
    if (acc) begin
      case (in_data.op)
        OP_NEEDLE: begin
          q_push       = 1'b1;
          q_data.kind  = JOB_NEEDLE;
          q_data.waddr = JOB_AW'(nidx_r);
          nidx_nxt     = (nidx_r == NAW'(ND - 1)) ? '0 : nidx_r + NAW'(1);
        end
        OP_HAY: begin
          q_push      = 1'b1;
          q_data.kind = check ? JOB_CHECK : JOB_HAY;
          if ({1'b0, hcol_r} + 12'd1 >= {1'b0, cfg.hw}) begin
            hcol_nxt = '0;
            if ({1'b0, hrow_r} + 12'd1 >= {1'b0, cfg.hh}) begin
              hrow_nxt  = '0;
              hline_nxt = '0;
              hbase_nxt = '0;
            end else begin
              hrow_nxt = hrow_r + 11'd1;
              if (hline_r == LNW'(NEEDLE_MAX_H - 1)) begin
                hline_nxt = '0;
                hbase_nxt = '0;
              end else begin
                hline_nxt = hline_r + LNW'(1);
                hbase_nxt = LAW'(hbase_r + LAW'(HAY_MAX_W));
              end
            end
          end else begin
            hcol_nxt = hcol_r + 11'd1;
          end
        end
        OP_RESTART: begin
          nidx_nxt  = '0;
          hcol_nxt  = '0;
          hrow_nxt  = '0;
          hline_nxt = '0;
          hbase_nxt = '0;
        end
        default: ;
      endcase
    end
    if (cfg_restart) begin
      nidx_nxt  = '0;
      hcol_nxt  = '0;
      hrow_nxt  = '0;
      hline_nxt = '0;
      hbase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nidx_r  <= '0;
      hcol_r  <= '0;
      hrow_r  <= '0;
      hline_r <= '0;
      hbase_r <= '0;
    end else begin
      nidx_r  <= nidx_nxt;
      hcol_r  <= hcol_nxt;
      hrow_r  <= hrow_nxt;
      hline_r <= hline_nxt;
      hbase_r <= hbase_nxt;
    end
  end

endmodule

// ===== hdl/tmm_back.sv =====
`timescale 1ns / 1ps
`include "tolerant_template_match_defines.svh"
module tmm_back #(
  parameter int NEEDLE_MAX_W = 32,
  parameter int NEEDLE_MAX_H = 32,
  parameter int HAY_MAX_W    = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tmm_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  tmm_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tmm_pkg::out_item_t out_data
);
  import tmm_pkg::*;

  localparam int ND  = NEEDLE_MAX_W * NEEDLE_MAX_H;
  localparam int NAW = (ND > 1) ? $clog2(ND) : 1;
  localparam int LNW = (NEEDLE_MAX_H > 1) ? $clog2(NEEDLE_MAX_H) : 1;
  localparam int LD  = NEEDLE_MAX_H * HAY_MAX_W;
  localparam int LAW = $clog2(LD);

  logic [31:0] nmem [ND];
  logic [31:0] lmem [LD];

  back_state_t    state_r, state_nxt;
  logic [NAW-1:0] naddr_r;
  logic [5:0]     c_r;
  logic [5:0]     r_r;
  logic [LNW-1:0] line_r;
  logic [LAW-1:0] lbase_r;
  logic [10:0]    lcol_r;
  logic [10:0]    left_r;
  logic [10:0]    top_r;
  logic           fail_r;
  logic           cmp_v_r;
  logic [31:0]    n_rd_r;
  logic [31:0]    l_rd_r;
  logic           out_v_r;
  out_item_t      out_r;

  logic           start, last, rd_en, n_we, l_we, out_load;
  logic [LAW-1:0] laddr;

  assign laddr     = LAW'(lbase_r + LAW'(lcol_r));
  assign last      = (c_r == cfg.nw - 6'd1) && (r_r == cfg.nh - 6'd1);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (start) state_nxt = B_RUN;
      B_RUN:   if (last) state_nxt = B_DRAIN;
      B_DRAIN: state_nxt = B_DONE;
      B_DONE:  if (fail_r || !out_v_r || out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_empty;
    start    = q_pop && (q_head.kind == JOB_CHECK);
    n_we     = q_pop && (q_head.kind == JOB_NEEDLE);
    l_we     = q_pop && (q_head.kind != JOB_NEEDLE);
    rd_en    = (state_r == B_RUN);
    out_load = (state_r == B_DONE) && !fail_r && (!out_v_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[q_head.waddr[NAW-1:0]] <= q_head.pixel;
    end
    if (rd_en) begin
      n_rd_r <= nmem[naddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[q_head.waddr[LAW-1:0]] <= q_head.pixel;
    end
    if (rd_en) begin
      l_rd_r <= lmem[laddr];
    end
  end

  // window walk: row-major, so the needle address just counts up
  always_ff @(posedge clk) begin
    if (start) begin
      naddr_r <= '0;
      c_r     <= '0;
      r_r     <= '0;
      line_r  <= LNW'(q_head.top_line);
      lbase_r <= LAW'(q_head.rbase);
      lcol_r  <= q_head.left;
      left_r  <= q_head.left;
      top_r   <= q_head.top;
    end else if (rd_en) begin
      naddr_r <= naddr_r + NAW'(1);
      if (c_r == cfg.nw - 6'd1) begin
        c_r    <= '0;
        r_r    <= r_r + 6'd1;
        lcol_r <= left_r;
        if (line_r == LNW'(NEEDLE_MAX_H - 1)) begin
          line_r  <= '0;
          lbase_r <= '0;
        end else begin
          line_r  <= line_r + LNW'(1);
          lbase_r <= LAW'(lbase_r + LAW'(HAY_MAX_W));
        end
      end else begin
        c_r    <= c_r + 6'd1;
        lcol_r <= lcol_r + 11'd1;
      end
    end
    if (out_load) begin
      out_r.match_left <= left_r[9:0];
      out_r.match_top  <= top_r[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cmp_v_r <= 1'b0;
      fail_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= rd_en;
      if (start) begin
        fail_r <= 1'b0;
      end else if (cmp_v_r && !pixels_agree(l_rd_r, n_rd_r, cfg.tol, cfg.lim)) begin
        fail_r <= 1'b1;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  `TMM_ASSERT(a_walk_bounds, (state_r == B_RUN) |-> (r_r < cfg.nh) && (c_r < cfg.nw))
  `TMM_ASSERT(a_drain_cmp, (state_r == B_DRAIN) |-> cmp_v_r)
  `TMM_NEVER(a_no_pop_busy, q_pop && (state_r != B_IDLE))
  `TMM_ASSERT(a_done_wait, (state_r == B_DONE) && !fail_r && out_v_r && !out_ready |=> (state_r == B_DONE))

endmodule

// ===== hdl/tolerant_template_match.sv =====
// Needle load or plain haystack pixel: queued, then written when the back is idle.
// Window check: walked one pixel pair per cycle; only a match gives a result.
// Throughput: 1 request/cycle unless the queue fills while a window check is running.
// rst_n (synchronous, active low) clears positions, queue, FSM and config.
// Needle and line stores are not cleared; unwritten entries read undefined.
`timescale 1ns / 1ps
module tolerant_template_match #(
  parameter int NEEDLE_MAX_W = 32,
  parameter int NEEDLE_MAX_H = 32,
  parameter int HAY_MAX_W    = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tmm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tmm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [tmm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [tmm_pkg::CFG_DW-1:0]    cfg_data
);
  import tmm_pkg::*;

  // Front decodes requests and tracks load positions; back owns both
  // stores and walks each completed window. A two-deep queue sits between.

  cfg_t  cfg_r, cfg_nxt;
  logic  cfg_restart;
  logic  q_push, q_full, q_pop, q_empty;
  job_t  q_in, q_head;

  // geometry writes restart load positions
  assign cfg_restart = cfg_we && (cfg_index <= CFG_HAY_H);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEEDLE_W: begin
          if (cfg_data[5:0] == 6'd0) cfg_nxt.nw = 6'd1;
          else if (int'(cfg_data[5:0]) > NEEDLE_MAX_W) cfg_nxt.nw = 6'(NEEDLE_MAX_W);
          else cfg_nxt.nw = cfg_data[5:0];
        end
        CFG_NEEDLE_H: begin
          if (cfg_data[5:0] == 6'd0) cfg_nxt.nh = 6'd1;
          else if (int'(cfg_data[5:0]) > NEEDLE_MAX_H) cfg_nxt.nh = 6'(NEEDLE_MAX_H);
          else cfg_nxt.nh = cfg_data[5:0];
        end
        CFG_HAY_W: begin
          if (cfg_data == 11'd0) cfg_nxt.hw = 11'd1;
          else if (int'(cfg_data) > HAY_MAX_W) cfg_nxt.hw = 11'(HAY_MAX_W);
          else cfg_nxt.hw = cfg_data;
        end
        CFG_HAY_H: begin
          if (cfg_data == 11'd0) cfg_nxt.hh = 11'd1;
          else if (int'(cfg_data) > HAY_MAX_H) cfg_nxt.hh = 11'(HAY_MAX_H);
          else cfg_nxt.hh = cfg_data;
        end
        CFG_TOL:  cfg_nxt.tol = cfg_data[8:0];
        CFG_OPAC: cfg_nxt.lim = cfg_data[7:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nw  <= 6'd1;
      cfg_r.nh  <= 6'd1;
      cfg_r.hw  <= 11'd1;
      cfg_r.hh  <= 11'd1;
      cfg_r.tol <= 9'd0;
      cfg_r.lim <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tmm_front #(
    .NEEDLE_MAX_W (NEEDLE_MAX_W),
    .NEEDLE_MAX_H (NEEDLE_MAX_H),
    .HAY_MAX_W    (HAY_MAX_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg         (cfg_r),
    .cfg_restart (cfg_restart),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  tmm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tmm_back #(
    .NEEDLE_MAX_W (NEEDLE_MAX_W),
    .NEEDLE_MAX_H (NEEDLE_MAX_H),
    .HAY_MAX_W    (HAY_MAX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tolerant_template_match_test.sv =====
`timescale 1ns / 1ps
module tolerant_template_match_test;
  import tmm_pkg::*;

  // Spare register indexes beyond the list; writes there must be ignored.
  localparam logic [CFG_IW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [1:0]        OP_UNUSED   = 2'd3;

  localparam int NW_MAX     = 32;
  localparam int NH_MAX     = 32;
  localparam int HW_MAX     = 1024;
  localparam int HH_MAX     = 1024;
  localparam int NEEDLE_ENT = NW_MAX * NH_MAX;
  localparam int LINE_ENT   = NH_MAX * HW_MAX;
  // A running check plus two queued 32x32 checks, each with a stalled
  // result, stay well under this.
  localparam int SETTLE_CYC = 3300;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 650;

  // Hay pixel sources.
  localparam int SRC_RANDOM = 0;
  localparam int SRC_TILED  = 1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  tolerant_template_match dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the matcher: stores, load positions and registers.
  // ---------------------------------------------------------------------
  logic [31:0] needle_mem [NEEDLE_ENT];
  logic [31:0] line_mem   [LINE_ENT];
  int unsigned needle_idx;
  int unsigned hay_col;
  int unsigned hay_row;
  int unsigned nw, nh, hw, hh;
  int unsigned tol;
  int unsigned lim;

  out_item_t   match_queue[$];   // positions still owed by the block
  int          error_count;
  int          idle_cycles;
  int          burst_left;
  int          stall_left;
  int          stall_mode;

  // Clock: 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_geom(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit channel_ok(logic [7:0] a, logic [7:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d <= tol;
  endfunction

  function automatic bit pair_ok(logic [31:0] h, logic [31:0] n);
    if (lim != 0 && (h[31:24] >= lim || n[31:24] >= lim)) return 1'b1;
    return channel_ok(h[7:0], n[7:0]) && channel_ok(h[15:8], n[15:8]) &&
           channel_ok(h[23:16], n[23:16]);
  endfunction

  function automatic bit window_ok(int unsigned left, int unsigned top);
    int unsigned base;
    for (int unsigned r = 0; r < nh; r++) begin
      base = ((top + r) % NH_MAX) * HW_MAX;
      for (int unsigned c = 0; c < nw; c++) begin
        if (!pair_ok(line_mem[(base + left + c) % LINE_ENT],
                     needle_mem[(r * nw + c) % NEEDLE_ENT]))
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void restart_positions();
    needle_idx = 0;
    hay_col    = 0;
    hay_row    = 0;
  endfunction

  // Update the shadow state for one accepted request; queue any match.
  function automatic void predict_match(in_item_t it);
    out_item_t m;
    case (it.op)
      OP_NEEDLE: begin
        needle_mem[needle_idx] = it.pixel;
        needle_idx = (needle_idx + 1) % NEEDLE_ENT;
      end
      OP_HAY: begin
        line_mem[((hay_row % NH_MAX) * HW_MAX + hay_col) % LINE_ENT] = it.pixel;
        if (hay_col + 1 >= nw && hay_row + 1 >= nh) begin
          if (window_ok(hay_col + 1 - nw, hay_row + 1 - nh)) begin
            m.match_left = 10'(hay_col + 1 - nw);
            m.match_top  = 10'(hay_row + 1 - nh);
            match_queue = {match_queue, m};
          end
        end
        if (hay_col + 1 >= hw) begin
          hay_col = 0;
          hay_row = (hay_row + 1 >= hh) ? 0 : hay_row + 1;
        end else begin
          hay_col = hay_col + 1;
        end
      end
      OP_RESTART: restart_positions();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checker and watchdog, both on the rising edge.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (match_queue.size() == 0) begin
        report_mismatch("unexpected match, left", out_data.match_left, 0);
      end else begin
        want = match_queue.pop_front();
        if (out_data.match_left !== want.match_left)
          report_mismatch("match_left", out_data.match_left, want.match_left);
        if (out_data.match_top !== want.match_top)
          report_mismatch("match_top", out_data.match_top, want.match_top);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls: stretches always ready, random, or blocked.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 40);
      stall_mode = $urandom_range(0, 2);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------
  // Send one request; the sender works in bursts with random gaps.
  task automatic send_request(logic [1:0] op, logic [31:0] pixel);
    in_item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    it.op    = op;
    it.pixel = pixel;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_match(it);
  endtask

  // Wait until every match is in, then until the back has drained.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (match_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_NEEDLE_W: begin nw = clamp_geom(val & 63, NW_MAX);   restart_positions(); end
      CFG_NEEDLE_H: begin nh = clamp_geom(val & 63, NH_MAX);   restart_positions(); end
      CFG_HAY_W:    begin hw = clamp_geom(val & 2047, HW_MAX); restart_positions(); end
      CFG_HAY_H:    begin hh = clamp_geom(val & 2047, HH_MAX); restart_positions(); end
      CFG_TOL:      tol = val & 511;
      CFG_OPAC:     lim = val & 255;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned xw, int unsigned xh);
    settle();
    write_reg(CFG_NEEDLE_W, w);
    write_reg(CFG_NEEDLE_H, h);
    write_reg(CFG_HAY_W, xw);
    write_reg(CFG_HAY_H, xh);
  endtask

  // Fill every needle entry the current geometry will read.
  task automatic load_needle();
    for (int unsigned i = 0; i < nw * nh; i++) send_request(OP_NEEDLE, $urandom);
  endtask

  // Hay pixel at the next position: random, or the needle tiled across the
  // haystack with the odd bit flipped so that some windows just miss.
  function automatic logic [31:0] next_hay_word(int src);
    logic [31:0] p;
    if (src == SRC_RANDOM) return $urandom;
    p = needle_mem[((hay_row % nh) * nw + hay_col % nw) % NEEDLE_ENT];
    if ($urandom_range(0, 15) == 0) p[$urandom_range(0, 31)] ^= 1'b1;
    return p;
  endfunction

  task automatic stream_hay(int unsigned count, int src);
    for (int unsigned i = 0; i < count; i++) send_request(OP_HAY, next_hay_word(src));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // 1x1 defaults after reset: exact compare, extremes, restart, unknown op.
  task automatic test_defaults();
    send_request(OP_NEEDLE, 32'h0000_0000);
    send_request(OP_HAY, 32'h0000_0000);
    send_request(OP_HAY, 32'hFFFF_FFFF);
    send_request(OP_HAY, 32'hFF00_0000);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(OP_RESTART, 32'h0000_0000);
    send_request(OP_NEEDLE, 32'hFFFF_FFFF);
    send_request(OP_HAY, 32'hFFFF_FFFF);
    send_request(OP_HAY, 32'h00FF_FFFF);
  endtask

  // Per-channel tolerance around the edges, including 255 and 256.
  task automatic test_tolerance();
    int unsigned tols [5] = '{0, 1, 254, 255, 256};
    settle();
    write_reg(CFG_OPAC, 0);
    foreach (tols[i]) begin
      settle();
      write_reg(CFG_TOL, tols[i]);
      send_request(OP_RESTART, 0);
      send_request(OP_NEEDLE, 32'h0080_FF00);
      send_request(OP_HAY, 32'h0081_FE01);
      send_request(OP_HAY, 32'h00FF_00FF);
    end
  endtask

  // Opacity skip at both ends of the limit, then writes to both spare indexes.
  task automatic test_opacity();
    settle();
    write_reg(CFG_TOL, 0);
    write_reg(CFG_OPAC, 255);
    send_request(OP_RESTART, 0);
    send_request(OP_NEEDLE, 32'hFE12_3456);
    send_request(OP_HAY, 32'hFF00_0000);
    send_request(OP_HAY, 32'hFE00_0000);
    settle();
    write_reg(CFG_OPAC, 1);
    send_request(OP_HAY, 32'h0100_0000);
    send_request(OP_HAY, 32'h0000_0001);
    settle();
    write_reg(CFG_SPARE_A, 2047);
    write_reg(CFG_SPARE_B, 0);
  endtask

  // Out-of-range geometry saturates; a needle taller than the haystack
  // never completes a window.
  task automatic test_geometry_saturation();
    settle();
    write_reg(CFG_OPAC, 0);
    set_geometry(0, 63, 2047, 0);
    stream_hay(8, SRC_RANDOM);
  endtask

  // Fill the whole needle store; one entry past the end wraps to entry
  // zero. Then the widest and the tallest needle rows walk the store,
  // the tall one across every line of the line store.
  task automatic test_large_needle();
    set_geometry(32, 32, 33, 33);
    write_reg(CFG_TOL, 2);
    load_needle();
    send_request(OP_NEEDLE, $urandom);
    set_geometry(32, 1, 33, 2);
    stream_hay(33 * 2, SRC_TILED);
    set_geometry(1, 32, 2, 33);
    stream_hay(2 * 33, SRC_TILED);
  endtask

  // Random phases of small geometry, mostly tiled streams with noise.
  task automatic test_random();
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      set_geometry($urandom_range(1, 4), $urandom_range(1, 4),
                   $urandom_range(1, 16), $urandom_range(1, 10));
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_TOL, 0);
        1:       write_reg(CFG_TOL, $urandom_range(0, 8));
        2:       write_reg(CFG_TOL, $urandom_range(254, 256));
        default: write_reg(CFG_TOL, $urandom_range(0, 511));
      endcase
      write_reg(CFG_OPAC, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 0);
      load_needle();
      sent += nw * nh;
      repeat ($urandom_range(20, 120)) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      send_request(OP_HAY, next_hay_word(SRC_TILED));
        else if (pick < 92) send_request(OP_HAY, next_hay_word(SRC_RANDOM));
        else if (pick < 95) send_request(OP_RESTART, $urandom);
        else if (pick < 98) send_request(OP_NEEDLE, $urandom);
        else                send_request(OP_UNUSED, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    error_count = 0;
    idle_cycles = 0;
    burst_left  = 0;
    stall_left  = 0;
    stall_mode  = 0;
    nw = 1; nh = 1; hw = 1; hh = 1; tol = 0; lim = 0;
    restart_positions();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_tolerance();
    test_opacity();
    test_geometry_saturation();
    test_large_needle();
    test_random();
    settle();

    if (match_queue.size() != 0)
      report_mismatch("matches never delivered", 0, match_queue.size());
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
